[rtl/bcpe_pkg.sv]
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the Bezier curve point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int COORD_W   = 16;   // signed q1.15 coordinate
    localparam int T_W       = 17;   // unsigned q1.16 curve parameter
    localparam int T_FRAC_W  = 16;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC_W);
    localparam int ROUND_HALF = 1 << (T_FRAC_W - 1);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_EVAL   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NO_POINTS = 2'd3
    } status_t;

    // one interpolation request for both coordinates
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } lerp_req_t;

    typedef struct packed {
        logic                      busy;
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } lerp_rsp_t;

endpackage

[rtl/bcpe_ram.sv]
// ----------------------------------------------------------------------------
// bcpe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bcpe_lerp.sv]
// ----------------------------------------------------------------------------
// bcpe_lerp
// Shared two-stage interpolation unit: p + round((q - p) * t / 65536) on x and
// y at once, exact half rounded toward plus infinity.
// ----------------------------------------------------------------------------
module bcpe_lerp
    import bcpe_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  lerp_req_t      req,
    input  logic [T_W-1:0] t,
    output lerp_rsp_t      rsp
);

    localparam int PROD_W = (COORD_W + 1) + (T_W + 1);

    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic signed [T_W:0]       t_s;
    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [PROD_W-1:0]  rnd_x;
    logic signed [PROD_W-1:0]  rnd_y;
    logic signed [COORD_W-1:0] p_x_reg;
    logic signed [COORD_W-1:0] p_y_reg;
    logic signed [COORD_W-1:0] res_x_next;
    logic signed [COORD_W-1:0] res_y_next;
    logic signed [COORD_W-1:0] res_x_reg;
    logic signed [COORD_W-1:0] res_y_reg;
    logic                      s1_valid_reg;
    logic                      out_valid_reg;

    assign t_s    = $signed({1'b0, t});
    assign diff_x = {req.qx[COORD_W-1], req.qx} - {req.px[COORD_W-1], req.px};
    assign diff_y = {req.qy[COORD_W-1], req.qy} - {req.py[COORD_W-1], req.py};

    assign prod_x_next = diff_x * t_s;
    assign prod_y_next = diff_y * t_s;

    // arithmetic shift gives the floor of the division
    assign rnd_x = (prod_x_reg + $signed(PROD_W'(ROUND_HALF))) >>> T_FRAC_W;
    assign rnd_y = (prod_y_reg + $signed(PROD_W'(ROUND_HALF))) >>> T_FRAC_W;

    // result lies between p and q, so the low bits of the sum are exact
    assign res_x_next = p_x_reg + rnd_x[COORD_W-1:0];
    assign res_y_next = p_y_reg + rnd_y[COORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= req.valid;
            out_valid_reg <= s1_valid_reg;
        end
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        p_x_reg    <= req.px;
        p_y_reg    <= req.py;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
    end

    assign rsp.busy  = s1_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.x     = res_x_reg;
    assign rsp.y     = res_y_reg;

endmodule

[rtl/bezier_curve_point_evaluator.sv]
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// Holds up to MAX_POINTS q1.15 control points and evaluates the Bezier curve
// they define at a q1.16 parameter t by de Casteljau interpolation. Add and
// remove transactions are answered in the cycle after they are accepted. An
// evaluate over n points runs levels of n down to 2 points through one shared
// two-stage interpolation unit, one interpolation per cycle within a level; each
// level reads its points and then waits for the unit to drain before the next
// level may read back. The block takes one transaction at a time and is not
// ready during an evaluate. t above 1.0 saturates to 1.0.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator
    import bcpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // point_x, point_y, t
    input  logic [KIND_W-1:0]    s_axis_tuser,  // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // curve_x, curve_y, point_count
    output logic [STATUS_W-1:0]  m_axis_tuser   // status
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int PAIR_W = 2 * COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_DRAIN,
        S_FINAL,
        S_FWAIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          held_count_reg, held_count_next;
    logic [T_W-1:0]            t_reg, t_next;
    logic [CNT_W-1:0]          lvl_reg, lvl_next;
    logic [ADDR_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]         wr_idx_reg, wr_idx_next;
    logic                      src_ctrl_reg, src_ctrl_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      rd_first_reg, rd_first_next;
    logic signed [COORD_W-1:0] p_x_reg, p_x_next;
    logic signed [COORD_W-1:0] p_y_reg, p_y_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [COORD_W-1:0] m_x_reg, m_x_next;
    logic signed [COORD_W-1:0] m_y_reg, m_y_next;
    logic [COUNT_W-1:0]        m_count_reg, m_count_next;
    status_t                   m_status_reg, m_status_next;

    logic                      s_accept;
    logic [T_W-1:0]            t_in;
    logic                      ctrl_we;
    logic                      ram_re;
    logic [PAIR_W-1:0]         ctrl_rdata;
    logic [PAIR_W-1:0]         work_rdata;
    logic [PAIR_W-1:0]         rd_data;
    logic signed [COORD_W-1:0] rd_x;
    logic signed [COORD_W-1:0] rd_y;
    lerp_req_t                 lerp_req;
    lerp_rsp_t                 lerp_rsp;

    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign t_in          = s_axis_tdata[2*COORD_W +: T_W];

    assign rd_data = src_ctrl_reg ? ctrl_rdata : work_rdata;
    assign rd_x    = rd_data[COORD_W-1:0];
    assign rd_y    = rd_data[PAIR_W-1:COORD_W];

    assign lerp_req.valid = rd_vld_reg && !rd_first_reg;
    assign lerp_req.px    = p_x_reg;
    assign lerp_req.py    = p_y_reg;
    assign lerp_req.qx    = rd_x;
    assign lerp_req.qy    = rd_y;

    bcpe_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_POINTS)
    ) u_ctrl_ram (
        .clk   (aclk),
        .we    (ctrl_we),
        .waddr (held_count_reg[ADDR_W-1:0]),
        .wdata (s_axis_tdata[PAIR_W-1:0]),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ctrl_rdata)
    );

    bcpe_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .clk   (aclk),
        .we    (lerp_rsp.valid),
        .waddr (wr_idx_reg),
        .wdata ({lerp_rsp.y, lerp_rsp.x}),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (work_rdata)
    );

    bcpe_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lerp_req),
        .t       (t_reg),
        .rsp     (lerp_rsp)
    );

    always_comb begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        t_next          = t_reg;
        lvl_next        = lvl_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        src_ctrl_next   = src_ctrl_reg;
        rd_vld_next     = 1'b0;
        rd_first_next   = 1'b0;
        p_x_next        = p_x_reg;
        p_y_next        = p_y_reg;
        m_valid_next    = m_valid_reg;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        ctrl_we         = 1'b0;
        ram_re          = 1'b0;

        // previous point of the level follows the read stream
        if (rd_vld_reg) begin
            p_x_next = rd_x;
            p_y_next = rd_y;
        end
        if (lerp_rsp.valid) begin
            wr_idx_next = wr_idx_reg + 1'b1;
        end
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    m_valid_next  = 1'b1;
                    m_x_next      = '0;
                    m_y_next      = '0;
                    m_count_next  = COUNT_W'(held_count_reg);
                    m_status_next = ST_OK;
                    unique case (s_axis_tuser)
                        KIND_ADD: begin
                            if (held_count_reg < CNT_W'(MAX_POINTS)) begin
                                ctrl_we         = 1'b1;
                                held_count_next = held_count_reg + 1'b1;
                                m_count_next    = COUNT_W'(held_count_reg + 1'b1);
                            end else begin
                                m_status_next = ST_FULL;
                            end
                        end
                        KIND_REMOVE: begin
                            if (held_count_reg != '0) begin
                                held_count_next = held_count_reg - 1'b1;
                                m_count_next    = COUNT_W'(held_count_reg - 1'b1);
                            end else begin
                                m_status_next = ST_EMPTY;
                            end
                        end
                        KIND_EVAL: begin
                            if (held_count_reg == '0) begin
                                m_status_next = ST_NO_POINTS;
                            end else begin
                                // result is loaded at the end of the evaluate
                                m_valid_next  = 1'b0;
                                t_next        = (t_in > T_ONE) ? T_ONE : t_in;
                                lvl_next      = held_count_reg;
                                rd_idx_next   = '0;
                                wr_idx_next   = '0;
                                src_ctrl_next = 1'b1;
                                state_next    = (held_count_reg == CNT_W'(1)) ? S_FINAL
                                                                               : S_LEVEL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEVEL: begin
                ram_re        = 1'b1;
                rd_vld_next   = 1'b1;
                rd_first_next = (rd_idx_reg == '0);
                if (rd_idx_reg == ADDR_W'(lvl_reg - 1'b1)) begin
                    state_next = S_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                // all writes of this level must land before the next one reads
                if (!rd_vld_reg && !lerp_rsp.busy && !lerp_rsp.valid) begin
                    src_ctrl_next = 1'b0;
                    lvl_next      = lvl_reg - 1'b1;
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    state_next    = (lvl_reg == CNT_W'(2)) ? S_FINAL : S_LEVEL;
                end
            end
            S_FINAL: begin
                ram_re     = 1'b1;
                state_next = S_FWAIT;
            end
            S_FWAIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_x_next      = rd_x;
                    m_y_next      = rd_y;
                    m_count_next  = COUNT_W'(held_count_reg);
                    m_status_next = ST_OK;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            held_count_reg <= '0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            src_ctrl_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            rd_vld_reg     <= rd_vld_next;
            rd_first_reg   <= rd_first_next;
            m_valid_reg    <= m_valid_next;
            src_ctrl_reg   <= src_ctrl_next;
        end
        t_reg        <= t_next;
        lvl_reg      <= lvl_next;
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        p_x_reg      <= p_x_next;
        p_y_reg      <= p_y_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_count_reg  <= m_count_next;
        m_status_reg <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - PAIR_W - COUNT_W)'(0), m_count_reg, m_y_reg, m_x_reg};
    assign m_axis_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_lerp_in_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        lerp_rsp.valid |-> (state_reg == S_LEVEL || state_reg == S_DRAIN))
        else $error("interpolation result outside an evaluate");

    a_ready_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (!rd_vld_reg && !lerp_rsp.busy && !lerp_rsp.valid))
        else $error("ready while the interpolation pipe is busy");

    a_add_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tuser == KIND_ADD && held_count_reg < CNT_W'(MAX_POINTS))
        |=> held_count_reg == CNT_W'($past(held_count_reg) + 1'b1))
        else $error("accepted add did not grow the list");
`endif

endmodule
